### design/cdq_pkg.sv
// cdq_pkg: shared types, constants and helpers of the coalescing update queue
// depends on nothing; imported by cdq_entry_ram and the top level
package cdq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_ADDR_W  = 3;

  localparam logic [31:0] DELAY_RESET = 32'd30;

  // register index taken from paddr above the byte offset
  localparam logic REG_DELAY = 1'b0;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_FORCE = 2'd2,
    CMD_TICK  = 2'd3
  } cdq_cmd_t;

  typedef enum logic [2:0] {
    STS_NEW     = 3'd0,
    STS_MERGED  = 3'd1,
    STS_FULL    = 3'd2,
    STS_POPPED  = 3'd3,
    STS_NOT_DUE = 3'd4,
    STS_TICK    = 3'd5
  } cdq_status_t;

  typedef struct packed {
    logic [31:0] user;
    logic [31:0] field;
    logic [31:0] amount;
    logic [31:0] stamp;
  } cdq_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    cdq_entry_t       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } cdq_ram_req_t;

  // ring slot of base plus offset, offset at most QUEUE_DEPTH
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, base} + (IDX_W + 1)'(off);
    if (s >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (IDX_W + 1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

### design/cdq_entry_ram.sv
// cdq_entry_ram: entry store, one write and one registered read per cycle
// depends on cdq_pkg (entry word and request struct)
module cdq_entry_ram (
  input  logic                  clk,
  input  cdq_pkg::cdq_ram_req_t req,
  output cdq_pkg::cdq_entry_t   rdata
);
  import cdq_pkg::*;

  cdq_entry_t mem [QUEUE_DEPTH];
  cdq_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/coalescing_delayed_update_queue_top.sv
// coalescing_delayed_update_queue_top: write-combining update fifo with age release
// depends on cdq_pkg and cdq_entry_ram
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+----------------------------------------
//   in      | input     | in_valid / in_stall    | command, user_id, field_id, amount
//   out     | output    | out_valid / out_stall  | status, user, field, amount, queued time
//   cfg     | input     | psel/penable, pready=1 | delay_seconds at byte address 0
//
// pop: one entry memory read, then age check; an empty queue is answered without a read
// push: a key search from the head, then a new entry or a full drop, or a merge write
//   to the matching entry; the key search reads one entry per cycle through the single
//   read port of the entry memory, and stops at a match
// reset (rst_n low, synchronous) empties the queue, zeroes the seconds counter and
//   sets the delay to 30; entry memory contents are not cleared
// a word is taken while a finished result still waits in the output register;
//   only the final handoff into that register waits on out_stall
module coalescing_delayed_update_queue_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_command,
  input  logic [31:0]                  in_user_id,
  input  logic [31:0]                  in_field_id,
  input  logic signed [31:0]           in_amount,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_status,
  output logic [31:0]                  out_user_id,
  output logic [31:0]                  out_field_id,
  output logic signed [31:0]           out_amount,
  output logic [31:0]                  out_queued_time,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cdq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cdq_pkg::*;

  // one-hot sequencer
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_MERGE = 5'b00100,
    ST_POP   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // queue bookkeeping
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [31:0]      delay_r;

  // request held while it is worked on
  logic [1:0]  req_cmd_r;
  logic [31:0] req_user_r, req_field_r, req_amount_r;

  // key search pipeline: issue index, compare stage
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0] cmp_slot_r;
  logic [IDX_W-1:0] hit_slot_r;
  cdq_entry_t       hit_word_r;

  // staged result, then output register
  logic [2:0]  res_status_r, res_status_nxt;
  logic [31:0] res_user_r, res_user_nxt;
  logic [31:0] res_field_r, res_field_nxt;
  logic [31:0] res_amount_r, res_amount_nxt;
  logic [31:0] res_stamp_r, res_stamp_nxt;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_user_r, out_field_r, out_amount_r, out_stamp_r;

  cdq_ram_req_t ram_req;
  cdq_entry_t   ram_rdata;

  logic             accept;
  logic             out_free;
  logic             issue;
  logic             key_hit;
  logic [IDX_W-1:0] scan_slot;
  logic [IDX_W-1:0] tail_slot;
  logic [32:0]      merge_sum;
  logic [31:0]      merge_amt;
  logic [31:0]      age;
  logic             due;
  logic             cfg_wr;

  cdq_entry_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // search reads entry idx from the head; the compare happens in the next cycle
  assign issue     = (state_r == ST_SCAN) && (idx_r < count_r);
  assign scan_slot = slot_add(head_r, idx_r);
  assign tail_slot = slot_add(head_r, count_r);
  assign key_hit   = cmp_v_r && (ram_rdata.user == req_user_r)
                     && (ram_rdata.field == req_field_r);

  // saturating q16.16 add on merge
  assign merge_sum = {hit_word_r.amount[31], hit_word_r.amount}
                     + {req_amount_r[31], req_amount_r};
  always_comb begin
    if (merge_sum[32] != merge_sum[31]) begin
      merge_amt = merge_sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      merge_amt = merge_sum[31:0];
    end
  end

  // head age with wraparound, strictly past the delay
  assign age = now_r - ram_rdata.stamp;
  assign due = (req_cmd_r == CMD_FORCE) || (age > delay_r);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    now_nxt        = now_r;
    idx_nxt        = idx_r;
    cmp_v_nxt      = 1'b0;
    res_status_nxt = res_status_r;
    res_user_nxt   = res_user_r;
    res_field_nxt  = res_field_r;
    res_amount_nxt = res_amount_r;
    res_stamp_nxt  = res_stamp_r;

    ram_req.we     = 1'b0;
    ram_req.waddr  = tail_slot;
    ram_req.wdata  = '{user: req_user_r, field: req_field_r,
                      amount: req_amount_r, stamp: now_r};
    ram_req.re     = 1'b0;
    ram_req.raddr  = scan_slot;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_user_nxt   = '0;
          res_field_nxt  = '0;
          res_amount_nxt = '0;
          res_stamp_nxt  = '0;
          case (in_command)
            CMD_PUSH: begin
              idx_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            CMD_TICK: begin
              now_nxt        = now_r + 32'd1;
              res_status_nxt = STS_TICK;
              state_nxt      = ST_FIN;
            end
            default: begin
              // pop: fetch the head entry, or report nothing due on empty
              if (count_r == '0) begin
                res_status_nxt = STS_NOT_DUE;
                state_nxt      = ST_FIN;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = head_r;
                state_nxt     = ST_POP;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        ram_req.re = issue;
        cmp_v_nxt  = issue;
        if (issue) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (key_hit) begin
          ram_req.re = 1'b0;
          cmp_v_nxt  = 1'b0;
          state_nxt  = ST_MERGE;
        end else if (!issue) begin
          // whole queue searched without a match
          if (count_r == CNT_W'(QUEUE_DEPTH)) begin
            res_status_nxt = STS_FULL;
          end else begin
            ram_req.we     = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
            res_status_nxt = STS_NEW;
          end
          state_nxt = ST_FIN;
        end
      end
      ST_MERGE: begin
        ram_req.we     = 1'b1;
        ram_req.waddr  = hit_slot_r;
        ram_req.wdata  = '{user: hit_word_r.user, field: hit_word_r.field,
                          amount: merge_amt, stamp: hit_word_r.stamp};
        res_status_nxt = STS_MERGED;
        state_nxt      = ST_FIN;
      end
      ST_POP: begin
        if (due) begin
          res_status_nxt = STS_POPPED;
          res_user_nxt   = ram_rdata.user;
          res_field_nxt  = ram_rdata.field;
          res_amount_nxt = ram_rdata.amount;
          res_stamp_nxt  = ram_rdata.stamp;
          head_nxt       = slot_add(head_r, CNT_W'(1));
          count_nxt      = count_r - CNT_W'(1);
        end else begin
          res_status_nxt = STS_NOT_DUE;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      now_r   <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      now_r   <= now_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
  end

  // payload-side registers, no reset needed
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_user_r   <= res_user_nxt;
    res_field_r  <= res_field_nxt;
    res_amount_r <= res_amount_nxt;
    res_stamp_r  <= res_stamp_nxt;
    if (accept) begin
      req_cmd_r    <= in_command;
      req_user_r   <= in_user_id;
      req_field_r  <= in_field_id;
      req_amount_r <= in_amount;
    end
    if (issue) begin
      cmp_slot_r <= scan_slot;
    end
    if (state_r == ST_SCAN && key_hit) begin
      hit_slot_r <= cmp_slot_r;
      hit_word_r <= ram_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_status_r <= res_status_r;
      out_user_r   <= res_user_r;
      out_field_r  <= res_field_r;
      out_amount_r <= res_amount_r;
      out_stamp_r  <= res_stamp_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_user_id     = out_user_r;
  assign out_field_id    = out_field_r;
  assign out_amount      = out_amount_r;
  assign out_queued_time = out_stamp_r;

  // configuration: delay register at index 0, other indexes ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_DELAY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (cfg_wr) begin
      delay_r <= pwdata;
    end
  end

  assign prdata = (paddr[CFG_ADDR_W-1] == REG_DELAY) ? delay_r : 32'd0;

  // fill level never passes the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // fill level moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CNT_W'(1) || count_r == $past(count_r) - CNT_W'(1)))
    else $error("entry count jumped");

  // merge only follows a search hit
  a_merge_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> $past(state_r == ST_SCAN))
    else $error("merge without search");

  // a new result word only comes out of the final state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result word without finish");

  // anything but a pop carries zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STS_POPPED) |->
      (out_user_r == '0 && out_field_r == '0 && out_amount_r == '0 && out_stamp_r == '0))
    else $error("nonzero payload on non-pop result");

endmodule
